// ===== hw/rtl/cmbl_pkg.sv =====
// Shared types and constants for the combined LCG shuffle generator.
// Depends on nothing; every other file in hw/rtl but cmbl_ram takes names from here.
package cmbl_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int WARMUP      = 8;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int VAL_W       = 31;
  localparam int FRAC_W      = 24;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + WARMUP);

  // Generator constants
  localparam logic [30:0] MOD_A   = 31'd2147483563;
  localparam logic [30:0] MOD_B   = 31'd2147483399;
  localparam logic [15:0] MUL_A   = 16'd40014;
  localparam logic [15:0] MUL_B   = 16'd40692;
  localparam logic [7:0]  FOLD_A  = 8'((64'd1 << 31) - 64'(MOD_A));
  localparam logic [7:0]  FOLD_B  = 8'((64'd1 << 31) - 64'(MOD_B));
  localparam logic [30:0] WRAP_ADD = MOD_A - 31'd1;

  // Slot select: shuffle word divided by SLOT_DIV via a reciprocal
  localparam longint unsigned SLOT_DIV_L  = 64'd1 + (64'(MOD_A) - 64'd1) / TABLE_DEPTH;
  localparam int              RECIP_SHIFT = 40;
  localparam longint unsigned SLOT_RECIP_L = (64'd1 << RECIP_SHIFT) / SLOT_DIV_L;
  localparam int              SLOT_QW     = $clog2(TABLE_DEPTH) + 1;
  localparam int              SLOT_PROD_W = RECIP_SHIFT + SLOT_QW;
  localparam logic [31:0]     SLOT_DIV    = 32'(SLOT_DIV_L);

  localparam logic [FRAC_W-1:0] FRAC_CAP = 24'd16777214;

  typedef logic [VAL_W-1:0]       val_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [FRAC_W-1:0]      frac_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [SLOT_QW-1:0]     slotq_t;
  typedef logic [SLOT_PROD_W-1:0] sprod_t;
  typedef logic [55:0]            fprod_t;

  localparam sprod_t SLOT_RECIP = sprod_t'(SLOT_RECIP_L);

  // Result of one modular step
  typedef struct packed {
    logic done;
    val_t value;
  } lcg_res_t;

  // Slot index and fraction derived from a shuffle word
  typedef struct packed {
    logic  done;
    addr_t slot;
    frac_t frac;
  } shp_res_t;

endpackage

// ===== hw/rtl/cmbl_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// Depends on nothing.
module cmbl_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/cmbl_lehmer.sv =====
// One Lehmer step x * mul mod (2^31 - fold), two register stages.
// Depends on cmbl_pkg.
module cmbl_lehmer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cmbl_pkg::val_t    x,
  input  logic [15:0]       mul,
  input  logic [7:0]        fold,
  output cmbl_pkg::lcg_res_t res
);

  logic [46:0]    prod_r;
  logic           v1_r;
  logic           v2_r;
  cmbl_pkg::val_t value_r;
  logic [31:0]    sum;
  logic [31:0]    modv;

  // 2^31 == fold (mod m): fold the high part back onto the low part
  always_comb begin
    sum  = {1'b0, prod_r[30:0]} + 32'(prod_r[46:31] * fold);
    modv = 32'h8000_0000 - 32'(fold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
    if (start) begin
      prod_r <= {16'd0, x} * {31'd0, mul};
    end
    if (v1_r) begin
      value_r <= (sum >= modv) ? 31'(sum - modv) : sum[30:0];
    end
  end

  assign res.done  = v2_r;
  assign res.value = value_r;

endmodule

// ===== hw/rtl/cmbl_shape.sv =====
// Turns a shuffle word into the next table slot and a Q0.24 fraction.
// Depends on cmbl_pkg.
module cmbl_shape (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cmbl_pkg::val_t     val,
  output cmbl_pkg::shp_res_t res
);

  cmbl_pkg::val_t   v1_r;
  cmbl_pkg::sprod_t sprod_r;
  cmbl_pkg::frac_t  fq0_r;
  logic             s1_r;
  logic             s2_r;
  cmbl_pkg::addr_t  slot_r;
  cmbl_pkg::frac_t  frac_r;

  cmbl_pkg::slotq_t qe;
  cmbl_pkg::slotq_t q;
  logic [31:0]      rem;
  logic [24:0]      fq1;
  logic [24:0]      fsel;
  cmbl_pkg::fprod_t fprod;
  cmbl_pkg::fprod_t flhs;

  always_comb begin
    // slot: reciprocal estimate is exact or one low
    qe  = sprod_r[cmbl_pkg::RECIP_SHIFT +: cmbl_pkg::SLOT_QW];
    rem = {1'b0, v1_r} - 32'(32'(qe) * cmbl_pkg::SLOT_DIV);
    q   = (rem >= cmbl_pkg::SLOT_DIV) ? qe + 1'b1 : qe;
    if (q > cmbl_pkg::slotq_t'(cmbl_pkg::TABLE_DEPTH - 1)) begin
      q = cmbl_pkg::slotq_t'(cmbl_pkg::TABLE_DEPTH - 1);
    end
    // fraction: v >> 7 is exact or one low
    fq1   = {1'b0, fq0_r} + 25'd1;
    fprod = cmbl_pkg::fprod_t'(fq1) * cmbl_pkg::fprod_t'(cmbl_pkg::MOD_A);
    flhs  = cmbl_pkg::fprod_t'({v1_r, 24'd0});
    fsel  = (flhs >= fprod) ? fq1 : {1'b0, fq0_r};
    if (fsel > {1'b0, cmbl_pkg::FRAC_CAP}) begin
      fsel = {1'b0, cmbl_pkg::FRAC_CAP};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
      s2_r <= 1'b0;
    end else begin
      s1_r <= start;
      s2_r <= s1_r;
    end
    if (start) begin
      v1_r    <= val;
      sprod_r <= cmbl_pkg::sprod_t'(val) * cmbl_pkg::SLOT_RECIP;
      fq0_r   <= val[30:7];
    end
    if (s1_r) begin
      slot_r <= q[cmbl_pkg::ADDR_W-1:0];
      frac_r <= fsel[cmbl_pkg::FRAC_W-1:0];
    end
  end

  assign res.done = s2_r;
  assign res.slot = slot_r;
  assign res.frac = frac_r;

endmodule

// ===== hw/rtl/combined_lcg_shuffle_rng.sv =====
// Top level of the combined LCG generator with Bays-Durham shuffle table.
// Depends on cmbl_pkg, cmbl_ram, cmbl_lehmer and cmbl_shape.
//
// Usage
//   Input channel (in_valid/in_ready): one word per request. in_req_type 0
//   asks for the next draw, 1 reseeds with in_seed_value (0 acts as 1) and
//   then draws. A draw before any seed reseeds with 1 first.
//   Output channel (out_valid/out_ready): one word per request, the draw as
//   a 31-bit integer and as a Q0.24 fraction capped just below one.
// Draw and reseed path
//   A plain draw runs through the two Lehmer steps (multiply stage, fold
//   stage), which work side by side with one table read, and then through
//   the two-stage slot/fraction unit. No new request is taken until the
//   result is in the output register.
//   A reseed first runs each of the 40 warm-up and fill steps through the
//   two-stage Lehmer unit, one after another.
// Reset and stalls
//   Reset returns to idle in the unseeded state with no result pending.
//   While the receiver stalls, the result holds in the output register; a
//   new request may be accepted and worked on; its draw waits in shuffle_r and
//   its fraction in the slot/fraction unit until the output register frees up.
module combined_lcg_shuffle_rng (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req_type,
  input  logic [30:0]            in_seed_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [30:0]            out_draw_value,
  output logic [23:0]            out_unit_fraction
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_GO,
    ST_SEED_WAIT,
    ST_SLOT_WAIT,
    ST_DRAW_RD,
    ST_DRAW_WAIT,
    ST_DRAW_SHAPE,
    ST_DELIVER
  } state_t;

  state_t              state_r;
  logic                seeded_r;
  cmbl_pkg::val_t      seed_r;
  cmbl_pkg::val_t      first_r;
  cmbl_pkg::val_t      second_r;
  cmbl_pkg::val_t      shuffle_r;
  cmbl_pkg::cnt_t      j_r;
  logic                out_valid_r;
  cmbl_pkg::val_t      out_draw_r;
  cmbl_pkg::frac_t     out_frac_r;

  // datapath hookups
  logic                a_start;
  cmbl_pkg::val_t      a_x;
  cmbl_pkg::lcg_res_t  a_res;
  logic                b_start;
  cmbl_pkg::lcg_res_t  b_res;
  logic                shp_start;
  cmbl_pkg::val_t      shp_val;
  cmbl_pkg::shp_res_t  shp_res;
  logic                ram_we;
  cmbl_pkg::addr_t     ram_waddr;
  cmbl_pkg::val_t      ram_wdata;
  logic                ram_re;
  cmbl_pkg::val_t      ram_rdata;
  logic signed [32:0]  ydiff;
  cmbl_pkg::val_t      ynew;
  logic                fill_slot;
  logic                seed_last;
  logic                out_free;

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_draw_value    = out_draw_r;
  assign out_unit_fraction = out_frac_r;
  assign out_free          = !out_valid_r || out_ready;

  always_comb begin
    fill_slot = (j_r < cmbl_pkg::cnt_t'(cmbl_pkg::TABLE_DEPTH));
    seed_last = (j_r == '0);

    // table word minus second generator, wrapped into 1..MOD_A-1
    ydiff = $signed({2'b00, ram_rdata}) - $signed({2'b00, b_res.value});
    if (ydiff < 33'sd1) begin
      ydiff = ydiff + $signed({2'b00, cmbl_pkg::WRAP_ADD});
    end
    ynew = ydiff[30:0];

    // first generator: chain steps straight from its own result while seeding
    a_x     = (state_r == ST_SEED_WAIT) ? a_res.value : first_r;
    a_start = (state_r == ST_SEED_GO) || (state_r == ST_DRAW_RD) ||
              ((state_r == ST_SEED_WAIT) && a_res.done && !seed_last);
    b_start = (state_r == ST_DRAW_RD);

    shp_start = 1'b0;
    shp_val   = ynew;
    ram_we    = 1'b0;
    ram_waddr = shp_res.slot;
    ram_wdata = a_res.value;
    case (state_r)
      ST_SEED_WAIT: begin
        if (a_res.done) begin
          ram_we    = fill_slot;
          ram_waddr = j_r[cmbl_pkg::ADDR_W-1:0];
          shp_start = seed_last;
          shp_val   = a_res.value;
        end
      end
      ST_DRAW_WAIT: begin
        if (a_res.done) begin
          ram_we    = 1'b1;
          shp_start = 1'b1;
        end
      end
      default: begin
      end
    endcase

    ram_re = (state_r == ST_DRAW_RD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the taken word unless the deliver state loads a new one
      if (out_valid_r && out_ready && (state_r != ST_DELIVER)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            // latch the request; an unseeded draw acts as seed 1
            seed_r <= in_req_type ? in_seed_value : 31'd1;
            if (in_req_type || !seeded_r) begin
              state_r <= ST_SEED_INIT;
            end else begin
              state_r <= ST_DRAW_RD;
            end
          end
        end
        ST_SEED_INIT: begin
          first_r  <= (seed_r == '0) ? 31'd1 : seed_r;
          second_r <= (seed_r == '0) ? 31'd1 : seed_r;
          j_r      <= cmbl_pkg::cnt_t'(cmbl_pkg::TABLE_DEPTH + cmbl_pkg::WARMUP - 1);
          state_r  <= ST_SEED_GO;
        end
        ST_SEED_GO: begin
          state_r <= ST_SEED_WAIT;
        end
        ST_SEED_WAIT: begin
          if (a_res.done) begin
            first_r <= a_res.value;
            if (seed_last) begin
              // slot 0 holds the last fill value; derive the first slot from it
              shuffle_r <= a_res.value;
              seeded_r  <= 1'b1;
              state_r   <= ST_SLOT_WAIT;
            end else begin
              j_r <= j_r - 1'b1;
            end
          end
        end
        ST_SLOT_WAIT: begin
          if (shp_res.done) begin
            state_r <= ST_DRAW_RD;
          end
        end
        ST_DRAW_RD: begin
          state_r <= ST_DRAW_WAIT;
        end
        ST_DRAW_WAIT: begin
          if (a_res.done) begin
            first_r   <= a_res.value;
            second_r  <= b_res.value;
            shuffle_r <= ynew;
            state_r   <= ST_DRAW_SHAPE;
          end
        end
        ST_DRAW_SHAPE: begin
          if (shp_res.done) begin
            state_r <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_draw_r  <= shuffle_r;
            out_frac_r  <= shp_res.frac;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  cmbl_lehmer u_lcg_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (a_start),
    .x     (a_x),
    .mul   (cmbl_pkg::MUL_A),
    .fold  (cmbl_pkg::FOLD_A),
    .res   (a_res)
  );

  cmbl_lehmer u_lcg_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (b_start),
    .x     (second_r),
    .mul   (cmbl_pkg::MUL_B),
    .fold  (cmbl_pkg::FOLD_B),
    .res   (b_res)
  );

  cmbl_shape u_shape (
    .clk   (clk),
    .rst_n (rst_n),
    .start (shp_start),
    .val   (shp_val),
    .res   (shp_res)
  );

  cmbl_ram #(
    .WIDTH (cmbl_pkg::VAL_W),
    .DEPTH (cmbl_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (shp_res.slot),
    .rdata (ram_rdata)
  );

endmodule

// ===== dv/tb_combined_lcg_shuffle_rng.sv =====
// Self-checking testbench for combined_lcg_shuffle_rng: a predictor of the two
// Lehmer generators and the shuffle table scores every output word in order.
// Depends on cmbl_pkg and combined_lcg_shuffle_rng; needs nothing else.
`timescale 1ns / 100ps

module tb_combined_lcg_shuffle_rng;
  typedef cmbl_pkg::val_t  val_t;
  typedef cmbl_pkg::frac_t frac_t;

  typedef longint unsigned u64_t;

  // Request codes carried on in_req_type
  typedef enum logic {
    REQ_DRAW   = 1'b0,
    REQ_RESEED = 1'b1
  } req_e;

  typedef struct packed {
    val_t  value;
    frac_t frac;
  } draw_t;

  typedef struct packed {
    req_e req;
    val_t seed;
  } stim_t;

  localparam int   DEPTH      = cmbl_pkg::TABLE_DEPTH;
  localparam int   WARM_STEPS = 8;
  localparam u64_t MODULUS_A  = 64'd2147483563;
  localparam u64_t MODULUS_B  = 64'd2147483399;
  localparam u64_t MULT_A     = 64'd40014;
  localparam u64_t MULT_B     = 64'd40692;
  localparam u64_t WRAP_BACK  = MODULUS_A - 64'd1;
  localparam u64_t SLOT_WIDTH = 64'd1 + WRAP_BACK / DEPTH;
  localparam u64_t FRAC_MAX   = 64'd16777214;
  localparam val_t SEED_MOD_A = 31'd2147483563;
  localparam val_t SEED_MOD_B = 31'd2147483399;
  localparam val_t SEED_TOP   = 31'd2147483562;
  localparam val_t SEED_ONES  = 31'h7FFFFFFF;

  localparam int RANDOM_WORDS    = 1680;
  localparam int HOLD_OFF_CYCLES = 300;
  // Worst quiet stretch: long receiver hold-off plus a reseed, taken several times over
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int MAX_PRINTED     = 100;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  logic  in_req_type;
  val_t  in_seed_value;
  logic  out_valid;
  logic  out_ready;
  val_t  out_draw_value;
  frac_t out_unit_fraction;

  // Predictor state
  val_t lcg_a;
  val_t lcg_b;
  val_t shuffle_word;
  val_t shuffle_tbl [DEPTH];
  logic is_seeded;

  draw_t draw_expect_q [$];
  int    mismatch_count;
  int    idle_cycles;
  logic  hold_off_go;

  combined_lcg_shuffle_rng dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_seed_value     (in_seed_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_draw_value    (out_draw_value),
    .out_unit_fraction (out_unit_fraction)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic val_t lehmer_next(val_t x, u64_t mult, u64_t modulus);
    return val_t'((u64_t'(x) * mult) % modulus);
  endfunction

  // Load both generators with the seed, run the warm-up steps, then fill the
  // table from the top slot down with the last DEPTH values of generator A
  function automatic void reseed_model(val_t seed);
    val_t s;
    s = (seed == '0) ? val_t'(1) : seed;
    lcg_a = s;
    lcg_b = s;
    for (int j = DEPTH + WARM_STEPS - 1; j >= 0; j--) begin
      lcg_a = lehmer_next(lcg_a, MULT_A, MODULUS_A);
      if (j < DEPTH) shuffle_tbl[j] = lcg_a;
    end
    shuffle_word = shuffle_tbl[0];
    is_seeded = 1'b1;
  endfunction

  function automatic draw_t predict_draw(req_e req, val_t seed);
    int unsigned slot;
    longint      diff;
    u64_t        frac_wide;
    draw_t       res;
    if (req == REQ_RESEED) reseed_model(seed);
    else if (!is_seeded) reseed_model(val_t'(1));
    lcg_a = lehmer_next(lcg_a, MULT_A, MODULUS_A);
    lcg_b = lehmer_next(lcg_b, MULT_B, MODULUS_B);
    slot = int'(u64_t'(shuffle_word) / SLOT_WIDTH);
    if (slot >= DEPTH) slot = DEPTH - 1;
    // Slot content minus generator B, wrapped into 1..MODULUS_A-1
    diff = longint'(u64_t'(shuffle_tbl[slot])) - longint'(u64_t'(lcg_b));
    shuffle_tbl[slot] = lcg_a;
    if (diff < 1) diff = diff + longint'(WRAP_BACK);
    shuffle_word = val_t'(diff);
    frac_wide = (u64_t'(shuffle_word) << 24) / MODULUS_A;
    if (frac_wide > FRAC_MAX) frac_wide = FRAC_MAX;
    res.value = shuffle_word;
    res.frac  = frac_t'(frac_wide);
    return res;
  endfunction

  task automatic report_mismatch(string what, u64_t got, u64_t want);
    // Keep the log short on a badly broken design; every mismatch still counts
    if (mismatch_count < MAX_PRINTED)
      $display("%0t ERROR %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Score output words and log input words at the rising edge; also run the
  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    draw_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (draw_expect_q.size() == 0) begin
          report_mismatch("output word with nothing expected", u64_t'(out_draw_value), 0);
        end else begin
          want = draw_expect_q.pop_front();
          if (out_draw_value !== want.value)
            report_mismatch("draw_value", u64_t'(out_draw_value), u64_t'(want.value));
          if (out_unit_fraction !== want.frac)
            report_mismatch("unit_fraction", u64_t'(out_unit_fraction), u64_t'(want.frac));
        end
      end
      if (in_valid && in_ready)
        draw_expect_q.push_back(predict_draw(req_e'(in_req_type), in_seed_value));
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: switch among always-ready, a rotating stall pattern and random
  // stalls; on request, hold off for a long stretch so the block backs up
  initial begin : receiver
    logic [15:0] stall_bits;
    int unsigned mode;
    int unsigned left;
    out_ready = 1'b0;
    stall_bits = '1;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_go) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_go = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(16, 96);
          stall_bits = 16'($urandom);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: begin
            out_ready <= stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[15:1]};
          end
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Present one word at a falling edge and hold it until the block takes it;
  // return at the falling edge after acceptance
  task automatic offer_word(req_e req, val_t seed);
    in_req_type   <= req;
    in_seed_value <= seed;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (draw_expect_q.size() != 0);
  endtask

  function automatic val_t pick_seed();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return val_t'(1);
      2:       return SEED_MOD_A;
      3:       return SEED_MOD_B;
      4:       return SEED_TOP;
      5:       return SEED_ONES;
      default: return val_t'($urandom);
    endcase
  endfunction

  // Directed rows: unseeded draw first, zero seed, seeds at and above both
  // moduli (a multiple of modulus A freezes generator A at zero), bit patterns
  // on the seed, and draw words whose seed bits must be ignored. Every row is
  // scored by the predictor.
  stim_t directed_rows [] = '{
    '{REQ_DRAW,   SEED_ONES},
    '{REQ_DRAW,   '0},
    '{REQ_DRAW,   31'h2AAAAAAA},
    '{REQ_RESEED, '0},
    '{REQ_DRAW,   31'h55555555},
    '{REQ_RESEED, 31'd1},
    '{REQ_DRAW,   '0},
    '{REQ_RESEED, SEED_ONES},
    '{REQ_DRAW,   SEED_ONES},
    '{REQ_RESEED, SEED_MOD_A},
    '{REQ_DRAW,   '0},
    '{REQ_DRAW,   '0},
    '{REQ_DRAW,   '0},
    '{REQ_DRAW,   '0},
    '{REQ_RESEED, SEED_MOD_B},
    '{REQ_DRAW,   '0},
    '{REQ_DRAW,   '0},
    '{REQ_RESEED, SEED_TOP},
    '{REQ_DRAW,   '0},
    '{REQ_RESEED, 31'h55555555},
    '{REQ_DRAW,   '0},
    '{REQ_RESEED, 31'h2AAAAAAA},
    '{REQ_DRAW,   '0},
    '{REQ_DRAW,   '0}
  };

  initial begin : sender
    int unsigned burst_left;
    int unsigned gap;
    req_e        req;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_DRAW;
    in_seed_value  = '0;
    hold_off_go    = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    lcg_a          = '0;
    lcg_b          = val_t'(123456789);
    shuffle_word   = '0;
    is_seeded      = 1'b0;
    foreach (shuffle_tbl[k]) shuffle_tbl[k] = '0;

    // Hold reset, then release it once
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) offer_word(directed_rows[r].req, directed_rows[r].seed);
    drain_results();

    burst_left = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 300 || i == 1200) begin
        drain_results();
      end
      // Ask for a long receiver hold-off and keep offering words through it
      if (i == 600) hold_off_go = 1'b1;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req = ($urandom_range(0, 9) == 0) ? REQ_RESEED : REQ_DRAW;
      offer_word(req, (req == REQ_RESEED) ? pick_seed() : val_t'($urandom));
    end
    in_valid <= 1'b0;

    // Wait for the last words, then let the block settle before the verdict
    while (draw_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cmbl_pkg.sv
hw/rtl/cmbl_ram.sv
hw/rtl/cmbl_lehmer.sv
hw/rtl/cmbl_shape.sv
hw/rtl/combined_lcg_shuffle_rng.sv
dv/tb_combined_lcg_shuffle_rng.sv
